// ===== design/mtx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx_pkg
// shared types and constants for the lock table with per-lock data words
// ----------------------------------------------------------------------------
package mtx_pkg;

  localparam int LOCK_COUNT = 32;
  localparam int ENTRY_W    = $clog2(LOCK_COUNT);

  localparam int KIND_W = 2;
  localparam int IDX_W  = 5;
  localparam int ID_W   = 5;
  localparam int DATA_W = 32;
  localparam int CODE_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_WRITE   = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_READ_OK           = 3'd0,
    CODE_READ_FAIL         = 3'd1,
    CODE_WRITE_OK          = 3'd2,
    CODE_WRITE_FAIL        = 3'd3,
    CODE_RELEASE_OK        = 3'd4,
    CODE_RELEASE_FREE      = 3'd5,
    CODE_RELEASE_NOT_OWNER = 3'd6,
    CODE_UNKNOWN           = 3'd7
  } code_t;

  typedef struct packed {
    kind_t                    kind;
    logic [IDX_W-1:0]         lock_index;
    logic [ID_W-1:0]          requester_id;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    code_t                    result_code;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

// ===== design/mtx_lock_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx_lock_table
// lock state store plus the decision logic for one request per cycle, applied while upd_en is high
// ----------------------------------------------------------------------------
module mtx_lock_table (
  input  logic          clk,
  input  logic          rst_n,
  input  mtx_pkg::req_t req,
  input  logic          upd_en,
  output mtx_pkg::rsp_t rsp
);
  import mtx_pkg::*;

  logic [LOCK_COUNT-1:0] held_r;
  logic [LOCK_COUNT-1:0] written_r;
  logic [ID_W-1:0]       owner_r [LOCK_COUNT];
  logic [DATA_W-1:0]     data_r  [LOCK_COUNT];

  logic [ENTRY_W-1:0] sel;
  logic               in_range;
  logic               cur_held;
  logic [ID_W-1:0]    cur_owner;
  logic [DATA_W-1:0]  cur_data;
  logic               take;
  logic               free;
  logic               store;

  assign sel       = ENTRY_W'(req.lock_index);
  assign in_range  = int'(req.lock_index) < LOCK_COUNT;
  assign cur_held  = held_r[sel];
  assign cur_owner = owner_r[sel];
  // entries never written read as zero; the data words themselves have no reset
  assign cur_data  = written_r[sel] ? data_r[sel] : '0;

  always_comb begin
    take            = 1'b0;
    free            = 1'b0;
    store           = 1'b0;
    rsp.result_code = CODE_UNKNOWN;
    rsp.read_value  = '0;
    case (req.kind)
      KIND_READ: begin
        if (!in_range || cur_held) begin
          rsp.result_code = CODE_READ_FAIL;
        end else begin
          take            = 1'b1;
          rsp.result_code = CODE_READ_OK;
          rsp.read_value  = cur_data;
        end
      end
      KIND_WRITE: begin
        if (!in_range || (cur_held && cur_owner != req.requester_id)) begin
          rsp.result_code = CODE_WRITE_FAIL;
        end else begin
          // owner rewrite is harmless when the requester already holds it
          take            = 1'b1;
          store           = 1'b1;
          rsp.result_code = CODE_WRITE_OK;
        end
      end
      KIND_RELEASE: begin
        if (!in_range || !cur_held) begin
          rsp.result_code = CODE_RELEASE_FREE;
        end else if (cur_owner == req.requester_id) begin
          free            = 1'b1;
          rsp.result_code = CODE_RELEASE_OK;
        end else begin
          rsp.result_code = CODE_RELEASE_NOT_OWNER;
        end
      end
      default: begin
        rsp.result_code = CODE_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      written_r <= '0;
      for (int i = 0; i < LOCK_COUNT; i++) begin
        owner_r[i] <= '0;
      end
    end else if (upd_en) begin
      if (take) begin
        held_r[sel]  <= 1'b1;
        owner_r[sel] <= req.requester_id;
      end else if (free) begin
        held_r[sel]  <= 1'b0;
        owner_r[sel] <= '0;
      end
      if (store) begin
        written_r[sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && store) begin
      data_r[sel] <= req.write_value;
    end
  end

endmodule

// ===== design/mutex_table_with_data.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_table_with_data
// table of hardware locks, each with a held flag, an owner id and a data word
// ----------------------------------------------------------------------------
// usage:
//   a request enters on in_valid/in_ready carrying the operation (in_kind),
//   the lock addressed, the requester id and a data word for writes.
//   every request gives exactly one result on out_valid/out_ready: a result
//   code and the stored word for a successful read-lock (zero otherwise).
//   a request is captured in an input register; once the output register can
//   take its result, the lock entry is looked up, updated and the result
//   loaded into the output register.
//   one request per cycle is sustained while out_ready stays high; the
//   single-entry read-modify-write of the lock store sets that rate and
//   back-to-back requests to the same lock see each other's updates.
//   when the receiver holds out_ready low, the result stays put, one more
//   request is held in the input register and in_ready then drops.
//   reset clears every lock to free with no owner and a zero data word.
// ----------------------------------------------------------------------------
module mutex_table_with_data (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mtx_pkg::KIND_W-1:0]          in_kind,
  input  logic [mtx_pkg::IDX_W-1:0]           in_lock_index,
  input  logic [mtx_pkg::ID_W-1:0]            in_requester_id,
  input  logic signed [mtx_pkg::DATA_W-1:0]   in_write_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mtx_pkg::CODE_W-1:0]          out_result_code,
  output logic signed [mtx_pkg::DATA_W-1:0]   out_read_value
);
  import mtx_pkg::*;

  logic req_vld_r;
  req_t req_r;
  logic out_vld_r;
  rsp_t rsp_r;
  rsp_t rsp_nxt;
  logic adv;

  // request moves into the table when the output register can take its result
  assign adv      = req_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !req_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ready) begin
      req_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.kind         <= kind_t'(in_kind);
      req_r.lock_index   <= in_lock_index;
      req_r.requester_id <= in_requester_id;
      req_r.write_value  <= in_write_value;
    end
  end

  mtx_lock_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .upd_en (adv),
    .rsp    (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_code = rsp_r.result_code;
  assign out_read_value  = rsp_r.read_value;

endmodule
